>>> rtl/core/voxel_greedy_mesher_defines.svh
// Assertion macros shared by the mesher checker.
`ifndef VOXEL_GREEDY_MESHER_DEFINES_SVH
`define VOXEL_GREEDY_MESHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define VGM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mesher check failed");

// Next-cycle implication, disabled while reset is held.
`define VGM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mesher check failed");

`endif

>>> rtl/core/vgm_pkg.sv
// Shared types and constants of the voxel greedy mesher.
package vgm_pkg;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_FETCH   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TOP,
        ST_B_RA,
        ST_B_RB,
        ST_B_WR,
        ST_SC_RD,
        ST_SC_CHK,
        ST_WX_RD,
        ST_WX_CHK,
        ST_HT_RD,
        ST_HT_CHK,
        ST_CL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] block_type;
        logic [2:0] side;
        logic [4:0] origin_x;
        logic [4:0] origin_y;
        logic [4:0] origin_z;
        logic [4:0] extent_u;
        logic [4:0] extent_v;
        logic       back_face;
        logic       done_res;
    } t_quad;

endpackage

>>> rtl/core/vgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/vgm_seq.sv
// Sweep sequencer: clears the chunk, builds plane masks and grows merged quads.
module vgm_seq import vgm_pkg::*; #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16,
    localparam int MAXS = (SIZE_X > SIZE_Y) ? ((SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z)
                                            : ((SIZE_Y > SIZE_Z) ? SIZE_Y : SIZE_Z),
    localparam int CW = $clog2(MAXS + 1),
    localparam int VDEPTH = SIZE_X * SIZE_Y * SIZE_Z,
    localparam int VAW = $clog2(VDEPTH),
    localparam int PXY = SIZE_X * SIZE_Y,
    localparam int PYZ = SIZE_Y * SIZE_Z,
    localparam int PZX = SIZE_Z * SIZE_X,
    localparam int MDEPTH = (PXY > PYZ) ? ((PXY > PZX) ? PXY : PZX)
                                        : ((PYZ > PZX) ? PYZ : PZX),
    localparam int MAW = $clog2(MDEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_op,
    input  logic [3:0]     i_pos_x,
    input  logic [3:0]     i_pos_y,
    input  logic [3:0]     i_pos_z,
    input  logic [7:0]     i_voxel_type,
    input  logic           i_out_free,
    output logic           o_emit,
    output t_quad          o_quad,
    output logic           o_vox_we,
    output logic [VAW-1:0] o_vox_waddr,
    output logic [7:0]     o_vox_wdata,
    output logic [VAW-1:0] o_vox_raddr,
    input  logic [7:0]     i_vox_rdata,
    output logic           o_msk_we,
    output logic [MAW-1:0] o_msk_addr,
    output logic [7:0]     o_msk_wdata,
    input  logic [7:0]     i_msk_rdata
);

    t_state r_state, n_state;
    logic [VAW-1:0] r_clr, n_clr;
    logic           r_pass_back, n_pass_back;
    logic [1:0]     r_axis, n_axis;
    logic [CW:0]    r_slice, n_slice;
    logic [CW-1:0]  r_row, n_row, r_col, n_col;
    logic           r_done, n_done, r_mvalid, n_mvalid, r_isdone, n_isdone;
    logic [CW-1:0]  r_w, n_w, r_h, n_h, r_k, n_k, r_l, n_l;
    logic [7:0]     r_t, n_t, r_va, n_va;

    logic [CW-1:0]  su, sv, sd, cd, cx, cy, cz, roff, coff;
    logic [CW:0]    s1, mrow, mcol;
    logic [2*CW+1:0] mprod;
    logic [31:0]    vsum_r, vsum_w;
    logic           acc, wr_in, col_end, row_end, wx_in, ht_in, k_last, l_last, b_last;
    logic           b_ok, clr_last;
    logic [7:0]     vb;

    always_comb begin
        case (r_axis)
            2'd1:    begin sd = CW'(SIZE_Y); su = CW'(SIZE_Z); sv = CW'(SIZE_X); end
            2'd2:    begin sd = CW'(SIZE_Z); su = CW'(SIZE_X); sv = CW'(SIZE_Y); end
            default: begin sd = CW'(SIZE_X); su = CW'(SIZE_Y); sv = CW'(SIZE_Z); end
        endcase
    end

    assign s1       = r_slice + 1'b1;
    assign acc      = i_valid && (r_state == ST_IDLE);
    assign wr_in    = (32'(i_pos_x) < SIZE_X) && (32'(i_pos_y) < SIZE_Y)
                      && (32'(i_pos_z) < SIZE_Z);
    assign col_end  = r_col >= su;
    assign row_end  = r_row >= sv;
    assign wx_in    = ({1'b0, r_col} + {1'b0, r_w}) < {1'b0, su};
    assign ht_in    = ({1'b0, r_row} + {1'b0, r_h}) < {1'b0, sv};
    assign k_last   = ({1'b0, r_k} + 1'b1) == {1'b0, r_w};
    assign l_last   = ({1'b0, r_l} + 1'b1) == {1'b0, r_h};
    assign b_last   = (({1'b0, r_col} + 1'b1) == {1'b0, su})
                      && (({1'b0, r_row} + 1'b1) == {1'b0, sv});
    assign b_ok     = s1 < {1'b0, sd};
    assign clr_last = r_clr == VAW'(VDEPTH - 1);
    assign vb       = b_ok ? i_vox_rdata : 8'd0;

    // Voxel read coordinates: the near voxel first, then the far one.
    assign cd = (r_state == ST_B_RB) ? s1[CW-1:0] : r_slice[CW-1:0];
    always_comb begin
        case (r_axis)
            2'd1:    begin cx = r_row; cy = cd;    cz = r_col; end
            2'd2:    begin cx = r_col; cy = r_row; cz = cd;    end
            default: begin cx = cd;    cy = r_col; cz = r_row; end
        endcase
    end
    assign vsum_r = (32'(cx) * 32'(SIZE_Y) + 32'(cy)) * 32'(SIZE_Z) + 32'(cz);
    assign vsum_w = (32'(i_pos_x) * 32'(SIZE_Y) + 32'(i_pos_y)) * 32'(SIZE_Z)
                    + 32'(i_pos_z);
    assign o_vox_raddr = vsum_r[VAW-1:0];

    // Mask address: row and column offsets depend on the scan phase.
    always_comb begin
        case (r_state)
            ST_WX_RD: begin roff = '0;  coff = r_w; end
            ST_HT_RD: begin roff = r_h; coff = r_k; end
            ST_CL:    begin roff = r_l; coff = r_k; end
            default:  begin roff = '0;  coff = '0;  end
        endcase
    end
    assign mrow = {1'b0, r_row} + {1'b0, roff};
    assign mcol = {1'b0, r_col} + {1'b0, coff};
    assign mprod = (2*CW+2)'(mrow) * (2*CW+2)'(su) + (2*CW+2)'(mcol);
    assign o_msk_addr = mprod[MAW-1:0];

    assign o_ready = r_state == ST_IDLE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (clr_last) n_state = ST_IDLE;
            ST_IDLE:   if (acc && i_op == OP_FETCH) n_state = ST_TOP;
            ST_TOP: begin
                if (r_done) n_state = ST_EMIT;
                else if (!r_mvalid) n_state = ST_B_RA;
                else n_state = ST_SC_RD;
            end
            ST_B_RA:   n_state = ST_B_RB;
            ST_B_RB:   n_state = ST_B_WR;
            ST_B_WR:   n_state = b_last ? ST_SC_RD : ST_B_RA;
            ST_SC_RD: begin
                if (row_end) n_state = ST_TOP;
                else if (!col_end) n_state = ST_SC_CHK;
            end
            ST_SC_CHK: n_state = (i_msk_rdata == 8'd0) ? ST_SC_RD : ST_WX_RD;
            ST_WX_RD:  n_state = wx_in ? ST_WX_CHK : ST_HT_RD;
            ST_WX_CHK: n_state = (i_msk_rdata == r_t) ? ST_WX_RD : ST_HT_RD;
            ST_HT_RD:  n_state = ht_in ? ST_HT_CHK : ST_CL;
            ST_HT_CHK: n_state = (i_msk_rdata != r_t) ? ST_CL : ST_HT_RD;
            ST_CL:     if (k_last && l_last) n_state = ST_EMIT;
            ST_EMIT:   if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr;
        n_pass_back = r_pass_back;
        n_axis = r_axis;
        n_slice = r_slice;
        n_row = r_row;
        n_col = r_col;
        n_done = r_done;
        n_mvalid = r_mvalid;
        n_isdone = r_isdone;
        n_w = r_w;
        n_h = r_h;
        n_k = r_k;
        n_l = r_l;
        n_t = r_t;
        n_va = r_va;
        o_vox_we = 1'b0;
        o_vox_waddr = vsum_w[VAW-1:0];
        o_vox_wdata = i_voxel_type;
        o_msk_we = 1'b0;
        o_msk_wdata = 8'd0;
        o_emit = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_vox_we = 1'b1;
                o_vox_waddr = r_clr;
                o_vox_wdata = 8'd0;
                n_clr = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (acc && i_op == OP_WRITE) begin
                    o_vox_we = wr_in;
                end
                if (acc && i_op == OP_RESTART) begin
                    n_pass_back = 1'b1;
                    n_axis = 2'd0;
                    n_slice = '1;
                    n_row = '0;
                    n_col = '0;
                    n_done = 1'b0;
                    n_mvalid = 1'b0;
                end
            end
            ST_TOP: begin
                n_isdone = r_done;
                if (!r_done && !r_mvalid) begin
                    n_row = '0;
                    n_col = '0;
                end
            end
            ST_B_RB: n_va = r_slice[CW] ? 8'd0 : i_vox_rdata;
            ST_B_WR: begin
                o_msk_we = 1'b1;
                o_msk_wdata = (r_va == vb) ? 8'd0 : (r_pass_back ? vb : r_va);
                if (b_last) begin
                    n_row = '0;
                    n_col = '0;
                    n_mvalid = 1'b1;
                end else if (({1'b0, r_col} + 1'b1) == {1'b0, su}) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_SC_RD: begin
                if (row_end) begin
                    n_mvalid = 1'b0;
                    if (b_ok) begin
                        n_slice = s1;
                    end else begin
                        n_slice = '1;
                        if (r_axis != 2'd2) begin
                            n_axis = r_axis + 1'b1;
                        end else begin
                            n_axis = 2'd0;
                            if (r_pass_back) n_pass_back = 1'b0;
                            else n_done = 1'b1;
                        end
                    end
                end else if (col_end) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end
            end
            ST_SC_CHK: begin
                if (i_msk_rdata == 8'd0) begin
                    n_col = r_col + 1'b1;
                end else begin
                    n_t = i_msk_rdata;
                    n_w = CW'(1);
                end
            end
            ST_WX_RD: begin
                if (!wx_in) begin
                    n_h = CW'(1);
                    n_k = '0;
                end
            end
            ST_WX_CHK: begin
                if (i_msk_rdata == r_t) begin
                    n_w = r_w + 1'b1;
                end else begin
                    n_h = CW'(1);
                    n_k = '0;
                end
            end
            ST_HT_RD: begin
                if (!ht_in) begin
                    n_k = '0;
                    n_l = '0;
                end
            end
            ST_HT_CHK: begin
                if (i_msk_rdata != r_t) begin
                    n_k = '0;
                    n_l = '0;
                end else if (k_last) begin
                    n_h = r_h + 1'b1;
                    n_k = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_CL: begin
                o_msk_we = 1'b1;
                if (k_last) begin
                    n_k = '0;
                    n_l = r_l + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (!r_isdone) n_col = r_col + r_w;
                end
            end
            default: ;
        endcase
    end

    // Result fields; a done result carries zeros apart from its flag.
    always_comb begin
        o_quad = '0;
        o_quad.done_res = r_isdone;
        if (!r_isdone) begin
            o_quad.block_type = r_t;
            o_quad.side = {r_axis, !r_pass_back};
            o_quad.extent_u = 5'(r_w);
            o_quad.extent_v = 5'(r_h);
            o_quad.back_face = r_pass_back;
            case (r_axis)
                2'd1: begin
                    o_quad.origin_x = 5'(r_row);
                    o_quad.origin_y = 5'(s1);
                    o_quad.origin_z = 5'(r_col);
                end
                2'd2: begin
                    o_quad.origin_x = 5'(r_col);
                    o_quad.origin_y = 5'(r_row);
                    o_quad.origin_z = 5'(s1);
                end
                default: begin
                    o_quad.origin_x = 5'(s1);
                    o_quad.origin_y = 5'(r_col);
                    o_quad.origin_z = 5'(r_row);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_pass_back <= 1'b1;
            r_axis <= 2'd0;
            r_slice <= '1;
            r_row <= '0;
            r_col <= '0;
            r_done <= 1'b0;
            r_mvalid <= 1'b0;
            r_isdone <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_pass_back <= n_pass_back;
            r_axis <= n_axis;
            r_slice <= n_slice;
            r_row <= n_row;
            r_col <= n_col;
            r_done <= n_done;
            r_mvalid <= n_mvalid;
            r_isdone <= n_isdone;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_h <= n_h;
        r_k <= n_k;
        r_l <= n_l;
        r_t <= n_t;
        r_va <= n_va;
    end

endmodule

>>> rtl/core/voxel_greedy_mesher.sv
// Greedy mesher top level: chunk store, plane mask, sequencer and result register.
// A fetch builds each plane it needs by reading the near and far voxel of every mask entry
// and writing the entry, then scans the mask, checks runs and rows and clears the merged
// entries, all paced by the single read port of each RAM; one request at a time.
// After reset the chunk store is cleared before the first request is taken; the sweep
// then starts with the left back faces.
module voxel_greedy_mesher import vgm_pkg::*; #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [3:0] i_pos_x,
    input  logic [3:0] i_pos_y,
    input  logic [3:0] i_pos_z,
    input  logic [7:0] i_voxel_type,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_block_type,
    output logic [2:0] o_side,
    output logic [4:0] o_origin_x,
    output logic [4:0] o_origin_y,
    output logic [4:0] o_origin_z,
    output logic [4:0] o_extent_u,
    output logic [4:0] o_extent_v,
    output logic       o_back_face,
    output logic       o_done_res
);

    localparam int VDEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int VAW = $clog2(VDEPTH);
    localparam int PXY = SIZE_X * SIZE_Y;
    localparam int PYZ = SIZE_Y * SIZE_Z;
    localparam int PZX = SIZE_Z * SIZE_X;
    localparam int MDEPTH = (PXY > PYZ) ? ((PXY > PZX) ? PXY : PZX)
                                        : ((PYZ > PZX) ? PYZ : PZX);
    localparam int MAW = $clog2(MDEPTH);

    logic           vox_we, msk_we, emit, out_free;
    logic [VAW-1:0] vox_waddr, vox_raddr;
    logic [7:0]     vox_wdata, vox_rdata, msk_wdata, msk_rdata;
    logic [MAW-1:0] msk_addr;
    t_quad          quad, r_quad;
    logic           r_ovalid;

    assign out_free = !r_ovalid || i_ready;

    vgm_seq #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_voxel_type (i_voxel_type),
        .i_out_free   (out_free),
        .o_emit       (emit),
        .o_quad       (quad),
        .o_vox_we     (vox_we),
        .o_vox_waddr  (vox_waddr),
        .o_vox_wdata  (vox_wdata),
        .o_vox_raddr  (vox_raddr),
        .i_vox_rdata  (vox_rdata),
        .o_msk_we     (msk_we),
        .o_msk_addr   (msk_addr),
        .o_msk_wdata  (msk_wdata),
        .i_msk_rdata  (msk_rdata)
    );

    vgm_ram #(.WIDTH(8), .DEPTH(VDEPTH)) u_vox_ram (
        .i_clk   (i_clk),
        .i_we    (vox_we),
        .i_waddr (vox_waddr),
        .i_wdata (vox_wdata),
        .i_raddr (vox_raddr),
        .o_rdata (vox_rdata)
    );

    vgm_ram #(.WIDTH(8), .DEPTH(MDEPTH)) u_msk_ram (
        .i_clk   (i_clk),
        .i_we    (msk_we),
        .i_waddr (msk_addr),
        .i_wdata (msk_wdata),
        .i_raddr (msk_addr),
        .o_rdata (msk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_quad <= quad;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_block_type = r_quad.block_type;
    assign o_side       = r_quad.side;
    assign o_origin_x   = r_quad.origin_x;
    assign o_origin_y   = r_quad.origin_y;
    assign o_origin_z   = r_quad.origin_z;
    assign o_extent_u   = r_quad.extent_u;
    assign o_extent_v   = r_quad.extent_v;
    assign o_back_face  = r_quad.back_face;
    assign o_done_res   = r_quad.done_res;

endmodule

>>> rtl/core/vgm_checker.sv
// Port-level checker for the greedy mesher, bound to the top level.
`include "voxel_greedy_mesher_defines.svh"

module vgm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_block_type,
    input logic [2:0] o_side,
    input logic [4:0] o_extent_u,
    input logic [4:0] o_extent_v,
    input logic       o_back_face,
    input logic       o_done_res
);

    `VGM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_block_type) && $stable(o_extent_u))
    `VGM_ASSERT_NOW(a_done_zero, i_clk, i_rst_n, o_valid && o_done_res, o_block_type == 8'd0 && o_extent_u == 5'd0 && o_side == 3'd0)
    `VGM_ASSERT_NOW(a_quad_real, i_clk, i_rst_n, o_valid && !o_done_res, o_block_type != 8'd0 && o_extent_u != 5'd0 && o_extent_v != 5'd0)
    `VGM_ASSERT_NOW(a_side_pass, i_clk, i_rst_n, o_valid && !o_done_res, o_back_face != o_side[0] && o_side != 3'd6 && o_side != 3'd7)

endmodule

bind voxel_greedy_mesher vgm_checker u_vgm_checker (.*);

>>> bench/testbench.sv
// Self-checking testbench for the voxel greedy mesher: random writes, fetches and restarts.
module testbench;
    import vgm_pkg::*;

    localparam int CHUNK = 16;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Tracks the chunk and the sweep, and holds the quads still owed by the block.
    class mesh_scoreboard;
        bit [7:0] chunk[CHUNK*CHUNK*CHUNK];
        bit [7:0] plane[CHUNK*CHUNK];
        bit       back_pass;
        int       axis;
        int       slice;
        int       row;
        int       col;
        bit       finished;
        bit       plane_ready;
        t_quad    owed[$];
        int       errors;

        function new();
            foreach (chunk[i]) chunk[i] = 0;
            errors = 0;
            restart_sweep();
        endfunction

        function void restart_sweep();
            back_pass   = 1;
            axis        = 0;
            slice       = -1;
            row         = 0;
            col         = 0;
            finished    = 0;
            plane_ready = 0;
        endfunction

        function bit [7:0] voxel(int c[3]);
            if (c[0] < 0 || c[1] < 0 || c[2] < 0 ||
                c[0] >= CHUNK || c[1] >= CHUNK || c[2] >= CHUNK)
                return 0;
            return chunk[(c[0] * CHUNK + c[1]) * CHUNK + c[2]];
        endfunction

        function void build_plane();
            int u;
            int v;
            int c[3];
            bit [7:0] near_t;
            bit [7:0] far_t;
            u = (axis + 1) % 3;
            v = (axis + 2) % 3;
            for (int jv = 0; jv < CHUNK; jv++) begin
                for (int iu = 0; iu < CHUNK; iu++) begin
                    c[u] = iu;
                    c[v] = jv;
                    c[axis] = slice;
                    near_t = voxel(c);
                    c[axis] = slice + 1;
                    far_t = voxel(c);
                    plane[jv * CHUNK + iu] = (near_t == far_t) ? 8'd0 :
                                             (back_pass ? far_t : near_t);
                end
            end
            row = 0;
            col = 0;
            plane_ready = 1;
        endfunction

        function void next_plane();
            plane_ready = 0;
            if (slice + 1 < CHUNK) begin
                slice++;
                return;
            end
            slice = -1;
            if (axis < 2) begin
                axis++;
                return;
            end
            axis = 0;
            if (back_pass) back_pass = 0;
            else finished = 1;
        endfunction

        // Finds the next maximal rectangle of the sweep and clears it from the plane.
        function t_quad next_quad();
            t_quad q;
            int n;
            int w;
            int h;
            int org[3];
            bit [7:0] t;
            bit whole;
            q = '0;
            while (!finished) begin
                if (!plane_ready) build_plane();
                while (row < CHUNK) begin
                    while (col < CHUNK) begin
                        n = row * CHUNK + col;
                        t = plane[n];
                        if (t != 0) begin
                            w = 1;
                            h = 1;
                            while (col + w < CHUNK && plane[n + w] == t) w++;
                            while (row + h < CHUNK) begin
                                whole = 1;
                                for (int k = 0; k < w; k++)
                                    if (plane[n + k + h * CHUNK] != t) whole = 0;
                                if (!whole) break;
                                h++;
                            end
                            for (int l = 0; l < h; l++)
                                for (int k = 0; k < w; k++)
                                    plane[n + k + l * CHUNK] = 0;
                            org[axis] = slice + 1;
                            org[(axis + 1) % 3] = col;
                            org[(axis + 2) % 3] = row;
                            q.block_type = t;
                            q.side       = 3'(2 * axis + (back_pass ? 0 : 1));
                            q.origin_x   = 5'(org[0]);
                            q.origin_y   = 5'(org[1]);
                            q.origin_z   = 5'(org[2]);
                            q.extent_u   = 5'(w);
                            q.extent_v   = 5'(h);
                            q.back_face  = back_pass;
                            q.done_res   = 0;
                            col += w;
                            return q;
                        end
                        col++;
                    end
                    col = 0;
                    row++;
                end
                next_plane();
            end
            q.done_res = 1;
            return q;
        endfunction

        function void note_request(logic [1:0] op, logic [3:0] x, logic [3:0] y,
                                   logic [3:0] z, logic [7:0] t);
            case (op)
                OP_WRITE:   chunk[(int'(x) * CHUNK + int'(y)) * CHUNK + int'(z)] = t;
                OP_RESTART: restart_sweep();
                OP_FETCH:   owed = {owed, next_quad()};
                default: ;
            endcase
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_quad got);
            t_quad want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            compare("block_type", want.block_type, got.block_type);
            compare("side", want.side, got.side);
            compare("origin_x", want.origin_x, got.origin_x);
            compare("origin_y", want.origin_y, got.origin_y);
            compare("origin_z", want.origin_z, got.origin_z);
            compare("extent_u", want.extent_u, got.extent_u);
            compare("extent_v", want.extent_v, got.extent_v);
            compare("back_face", want.back_face, got.back_face);
            compare("done_res", want.done_res, got.done_res);
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_ready;
    logic [1:0] i_op = OP_NONE;
    logic [3:0] i_pos_x = 0;
    logic [3:0] i_pos_y = 0;
    logic [3:0] i_pos_z = 0;
    logic [7:0] i_voxel_type = 0;
    logic       o_valid;
    logic       i_ready = 0;
    t_quad      quad_out;
    int         requests_sent = 0;
    int         stall_left = 0;
    mesh_scoreboard sb = new();

    voxel_greedy_mesher dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_voxel_type (i_voxel_type),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_block_type (quad_out.block_type),
        .o_side       (quad_out.side),
        .o_origin_x   (quad_out.origin_x),
        .o_origin_y   (quad_out.origin_y),
        .o_origin_z   (quad_out.origin_z),
        .o_extent_u   (quad_out.extent_u),
        .o_extent_v   (quad_out.extent_v),
        .o_back_face  (quad_out.back_face),
        .o_done_res   (quad_out.done_res)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(logic [1:0] op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                        logic [7:0] t);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid      <= 1;
        i_op         <= op;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_pos_z      <= z;
        i_voxel_type <= t;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(op, x, y, z, t);
        requests_sent++;
    endtask

    task automatic fetch();
        send(OP_FETCH, 4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
    endtask

    // Writes clustered near the low corner so that quads, and merges, appear early.
    task automatic random_write();
        logic [7:0] t;
        int r;
        r = $urandom_range(0, 9);
        t = (r < 6) ? 8'($urandom_range(1, 3)) : (r < 8) ? 8'd0 : 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            send(OP_WRITE, 4'($urandom), 4'($urandom), 4'($urandom), t);
        else
            send(OP_WRITE, 4'($urandom_range(0, 3)), 4'($urandom_range(0, 5)),
                 4'($urandom_range(0, 5)), t);
    endtask

    // Result side: random back-pressure, occasionally long.
    always @(posedge i_clk) begin
        if (o_valid && i_ready) sb.check_result(quad_out);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= gap_len();
            i_ready    <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: corners, extreme types, idle opcode, fetch, restart.
        send(OP_WRITE, 4'd0, 4'd0, 4'd0, 8'd255);
        send(OP_WRITE, 4'd15, 4'd15, 4'd15, 8'd1);
        send(OP_WRITE, 4'd1, 4'd0, 4'd0, 8'd255);
        send(OP_WRITE, 4'd0, 4'd1, 4'd0, 8'd255);
        send(OP_WRITE, 4'd15, 4'd0, 4'd15, 8'd170);
        send(OP_WRITE, 4'd0, 4'd15, 4'd0, 8'd85);
        send(OP_NONE, 4'd15, 4'd15, 4'd15, 8'd255);
        repeat (4) fetch();
        // A write in the middle of a sweep only affects planes not yet built.
        send(OP_WRITE, 4'd0, 4'd0, 4'd1, 8'd255);
        repeat (3) fetch();
        send(OP_RESTART, 4'd0, 4'd0, 4'd0, 8'd0);
        send(OP_WRITE, 4'd15, 4'd15, 4'd15, 8'd0);
        repeat (4) fetch();
        send(OP_RESTART, 4'd15, 4'd15, 4'd15, 8'd255);

        // Run one sweep of the sparse chunk to its end, then confirm that done repeats.
        while (!sb.finished) fetch();
        repeat (3) fetch();
        send(OP_RESTART, 4'd0, 4'd0, 4'd0, 8'd0);

        // Random rounds: fill, fetch part of the sweep, and usually restart.
        while (requests_sent < 1200) begin
            repeat ($urandom_range(3, 25)) random_write();
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 9) == 0) random_write();
                if ($urandom_range(0, 19) == 0)
                    send(OP_NONE, 4'($urandom), 4'($urandom), 4'($urandom),
                         8'($urandom));
                fetch();
            end
            if ($urandom_range(0, 7) != 0)
                send(OP_RESTART, 4'($urandom), 4'($urandom), 4'($urandom),
                     8'($urandom));
        end

        send(OP_WRITE, 4'd2, 4'd2, 4'd2, 8'd7);

        i_valid <= 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(20 * 40_000_000);
        $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/vgm_pkg.sv
rtl/core/vgm_ram.sv
rtl/core/vgm_seq.sv
rtl/core/voxel_greedy_mesher.sv
rtl/core/vgm_checker.sv
bench/testbench.sv
